/* sv/rist_pkg.sv */
// rist_pkg: shared constants and types for the run interval stat tracker
// no dependencies; imported by every rist module and the core top level
package rist_pkg;

  localparam int TIME_BITS_DEF   = 48;
  localparam int SHIFT_W         = 4;
  localparam int COUNT_W         = 32;
  localparam int KIND_W          = 2;
  localparam logic [SHIFT_W-1:0] AVG_SHIFT_RESET = 4'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // handed from the beat staging register to the update logic
  typedef struct packed {
    logic  fire;
    kind_t kind;
  } rist_ctl_t;

endpackage

/* sv/rist_ema.sv */
// rist_ema: one moving average step, avg + ((x - avg) >>> shift)
// uses rist_pkg for the shift width; purely combinational
module rist_ema #(
  parameter int VW = rist_pkg::TIME_BITS_DEF + 1
) (
  input  logic signed [VW-1:0]            avg,
  input  logic signed [VW-1:0]            x,
  input  logic [rist_pkg::SHIFT_W-1:0]    shift,
  output logic signed [VW-1:0]            avg_nxt
);
  import rist_pkg::*;

  logic signed [VW:0] err;
  logic signed [VW:0] err_sh;

  // error term one bit wider so it never overflows
  assign err     = $signed({x[VW-1], x}) - $signed({avg[VW-1], avg});
  assign err_sh  = err >>> shift;
  assign avg_nxt = avg + err_sh[VW-1:0];

endmodule

/* sv/rist_update.sv */
// rist_update: statistics state and the single pass update for one event
// depends on rist_pkg and rist_ema
module rist_update #(
  parameter int TIME_BITS = rist_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rist_pkg::rist_ctl_t            ctl,
  input  logic [TIME_BITS-1:0]           timestamp,
  input  logic [rist_pkg::SHIFT_W-1:0]   avg_shift,
  output logic signed [TIME_BITS:0]      measured,
  output logic [rist_pkg::COUNT_W-1:0]   run_count,
  output logic signed [TIME_BITS:0]      avg_interval,
  output logic signed [TIME_BITS:0]      max_interval,
  output logic signed [TIME_BITS:0]      avg_run,
  output logic signed [TIME_BITS:0]      max_run
);
  import rist_pkg::*;

  localparam int VW = TIME_BITS + 1;

  logic [COUNT_W-1:0]   start_count_r, start_count_nxt;
  logic [TIME_BITS-1:0] start_stamp_r, start_stamp_nxt;
  logic signed [VW-1:0] run_accum_r, run_accum_nxt;
  logic signed [VW-1:0] iavg_r, iavg_nxt;
  logic signed [VW-1:0] ipeak_r, ipeak_nxt;
  logic signed [VW-1:0] ravg_r, ravg_nxt;
  logic signed [VW-1:0] rpeak_r, rpeak_nxt;

  logic signed [VW-1:0] diff;
  logic signed [VW-1:0] run_sum;
  logic signed [VW-1:0] iavg_upd;
  logic signed [VW-1:0] ravg_upd;
  logic signed [VW-1:0] meas;

  assign diff    = $signed({1'b0, timestamp} - {1'b0, start_stamp_r});
  assign run_sum = run_accum_r + diff;

  rist_ema #(.VW(VW)) u_ema_interval (
    .avg     (iavg_r),
    .x       (diff),
    .shift   (avg_shift),
    .avg_nxt (iavg_upd)
  );

  rist_ema #(.VW(VW)) u_ema_run (
    .avg     (ravg_r),
    .x       (run_sum),
    .shift   (avg_shift),
    .avg_nxt (ravg_upd)
  );

  always_comb begin
    start_count_nxt = start_count_r;
    start_stamp_nxt = start_stamp_r;
    run_accum_nxt   = run_accum_r;
    iavg_nxt        = iavg_r;
    ipeak_nxt       = ipeak_r;
    ravg_nxt        = ravg_r;
    rpeak_nxt       = rpeak_r;
    meas            = '0;
    case (ctl.kind)
      KIND_START: begin
        if (start_count_r != '0) begin
          meas     = diff;
          iavg_nxt = iavg_upd;
          if (diff > ipeak_r) begin
            ipeak_nxt = diff;
          end
        end else begin
          // first start after a clear wipes the statistics
          iavg_nxt  = '0;
          ipeak_nxt = '0;
          ravg_nxt  = '0;
          rpeak_nxt = '0;
        end
        if (start_count_r != COUNT_MAX) begin
          start_count_nxt = start_count_r + 1'b1;
        end
        start_stamp_nxt = timestamp;
        run_accum_nxt   = '0;
      end
      KIND_STOP: begin
        run_accum_nxt = run_sum;
        ravg_nxt      = ravg_upd;
        if (run_sum > rpeak_r) begin
          rpeak_nxt = run_sum;
        end
        meas = run_sum;
      end
      KIND_CLEAR: begin
        start_count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_count_r <= '0;
      start_stamp_r <= '0;
      run_accum_r   <= '0;
      iavg_r        <= '0;
      ipeak_r       <= '0;
      ravg_r        <= '0;
      rpeak_r       <= '0;
    end else if (ctl.fire) begin
      start_count_r <= start_count_nxt;
      start_stamp_r <= start_stamp_nxt;
      run_accum_r   <= run_accum_nxt;
      iavg_r        <= iavg_nxt;
      ipeak_r       <= ipeak_nxt;
      ravg_r        <= ravg_nxt;
      rpeak_r       <= rpeak_nxt;
    end
  end

  assign measured     = meas;
  assign run_count    = start_count_nxt;
  assign avg_interval = iavg_nxt;
  assign max_interval = ipeak_nxt;
  assign avg_run      = ravg_nxt;
  assign max_run      = rpeak_nxt;

  a_clear_zeroes_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && ctl.kind == KIND_CLEAR |=> start_count_r == '0)
    else $error("clear event left a nonzero start count");

  a_start_records_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && ctl.kind == KIND_START |=>
      start_stamp_r == $past(timestamp) && run_accum_r == '0)
    else $error("start event did not record its stamp or clear the run accumulator");

  a_first_start_wipes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && ctl.kind == KIND_START && start_count_r == '0 |=>
      iavg_r == '0 && ipeak_r == '0 && ravg_r == '0 && rpeak_r == '0)
    else $error("first start did not clear the statistics");

  a_run_peak_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && ctl.kind == KIND_STOP |=>
      rpeak_r >= $past(rpeak_r) && rpeak_r >= run_accum_r)
    else $error("run peak fell or is below the run time on a stop");

endmodule

/* sv/run_interval_stat_tracker_core.sv */
// run_interval_stat_tracker_core: top level with beat staging, result register and config
// depends on rist_pkg and rist_update (which uses rist_ema)
//
// Takes one start, stop or clear event per cycle while in_ready is high and returns exactly
// one result beat per event. An accepted beat is held in the input staging register, then the
// whole statistics update (difference, run accumulation, two moving averages, two peaks) runs
// in a single combinational pass and lands in the result register, so sustained throughput is
// one event per cycle as long as out_ready stays high. While a result waits the staging
// register still takes one more beat, then in_ready stays low until out_ready returns;
// in_ready follows out_ready combinationally in that case.
// average_shift resets to 4 and is written through the cfg channel, which is always ready;
// write it only while no event is in flight.
module run_interval_stat_tracker_core #(
  parameter int TIME_BITS = rist_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rist_pkg::KIND_W-1:0]    in_kind,
  input  logic [TIME_BITS-1:0]           in_timestamp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [TIME_BITS:0]      out_measured,
  output logic [rist_pkg::COUNT_W-1:0]   out_run_count,
  output logic signed [TIME_BITS:0]      out_avg_interval,
  output logic signed [TIME_BITS:0]      out_max_interval,
  output logic signed [TIME_BITS:0]      out_avg_run,
  output logic signed [TIME_BITS:0]      out_max_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rist_pkg::SHIFT_W-1:0]   cfg_data
);
  import rist_pkg::*;

  logic                   stg_valid_r;
  kind_t                  stg_kind_r;
  logic [TIME_BITS-1:0]   stg_ts_r;
  logic [SHIFT_W-1:0]     avg_shift_r;
  logic                   proc_fire;
  rist_ctl_t              ctl;

  logic signed [TIME_BITS:0]  upd_measured;
  logic [COUNT_W-1:0]         upd_run_count;
  logic signed [TIME_BITS:0]  upd_avg_interval;
  logic signed [TIME_BITS:0]  upd_max_interval;
  logic signed [TIME_BITS:0]  upd_avg_run;
  logic signed [TIME_BITS:0]  upd_max_run;

  logic                       out_valid_r;
  logic signed [TIME_BITS:0]  out_measured_r;
  logic [COUNT_W-1:0]         out_run_count_r;
  logic signed [TIME_BITS:0]  out_avg_interval_r;
  logic signed [TIME_BITS:0]  out_max_interval_r;
  logic signed [TIME_BITS:0]  out_avg_run_r;
  logic signed [TIME_BITS:0]  out_max_run_r;

  // staged beat moves on when the result register is free or being drained
  assign proc_fire = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || proc_fire;
  assign cfg_ready = 1'b1;

  assign ctl.fire = proc_fire;
  assign ctl.kind = stg_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_kind_r <= kind_t'(in_kind);
      stg_ts_r   <= in_timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_shift_r <= AVG_SHIFT_RESET;
    end else if (cfg_valid) begin
      avg_shift_r <= cfg_data;
    end
  end

  rist_update #(.TIME_BITS(TIME_BITS)) u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .timestamp    (stg_ts_r),
    .avg_shift    (avg_shift_r),
    .measured     (upd_measured),
    .run_count    (upd_run_count),
    .avg_interval (upd_avg_interval),
    .max_interval (upd_max_interval),
    .avg_run      (upd_avg_run),
    .max_run      (upd_max_run)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_measured_r     <= upd_measured;
      out_run_count_r    <= upd_run_count;
      out_avg_interval_r <= upd_avg_interval;
      out_max_interval_r <= upd_max_interval;
      out_avg_run_r      <= upd_avg_run;
      out_max_run_r      <= upd_max_run;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_measured     = out_measured_r;
  assign out_run_count    = out_run_count_r;
  assign out_avg_interval = out_avg_interval_r;
  assign out_max_interval = out_max_interval_r;
  assign out_avg_run      = out_avg_run_r;
  assign out_max_run      = out_max_run_r;

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !proc_fire)
    else $error("result overwritten while waiting");

  a_staged_beat_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |=> out_valid_r)
    else $error("processed beat produced no result");

  a_stage_held_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !proc_fire |=> stg_valid_r && $stable(stg_ts_r) && $stable(stg_kind_r))
    else $error("staged beat dropped or changed while blocked");

endmodule

/* test/tb_run_interval_stat_tracker_core.sv */
`timescale 1ns / 100ps
// tb_run_interval_stat_tracker_core: self-checking bench for the run interval stat tracker
// depends on rist_pkg and run_interval_stat_tracker_core; predicts every result beat in place
module tb_run_interval_stat_tracker_core;
  import rist_pkg::*;

  localparam int TIME_W      = TIME_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef logic signed [TIME_W:0] val_t;
  typedef logic [TIME_W-1:0]      stamp_t;

  typedef struct {
    val_t               measured;
    logic [COUNT_W-1:0] count;
    val_t               avg_iv;
    val_t               max_iv;
    val_t               avg_rn;
    val_t               max_rn;
  } stats_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind = '0;
  stamp_t             in_timestamp = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  val_t               out_measured;
  logic [COUNT_W-1:0] out_run_count;
  val_t               out_avg_interval;
  val_t               out_max_interval;
  val_t               out_avg_run;
  val_t               out_max_run;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SHIFT_W-1:0] cfg_data = '0;

  // tracker state as the block should hold it
  logic [COUNT_W-1:0] start_total = '0;
  stamp_t             last_start = '0;
  val_t               run_total = '0;
  val_t               iv_avg = '0;
  val_t               iv_peak = '0;
  val_t               run_avg = '0;
  val_t               run_peak = '0;
  logic [SHIFT_W-1:0] avg_shift = AVG_SHIFT_RESET;

  stats_t pending_stats[$];
  int     errors = 0;
  int     events_sent = 0;
  int     results_seen = 0;
  int     shifts_written = 0;
  int     kind_seen[4] = '{0, 0, 0, 0};
  int     send_idle_pct = 6;
  int     recv_idle_pct = 47;
  int     quiet_cycles = 0;

  run_interval_stat_tracker_core #(
    .TIME_BITS(TIME_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_measured     (out_measured),
    .out_run_count    (out_run_count),
    .out_avg_interval (out_avg_interval),
    .out_max_interval (out_max_interval),
    .out_avg_run      (out_avg_run),
    .out_max_run      (out_max_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // avg + ((sample - avg) >>> shift), error term one bit wider than the value
  function automatic val_t fold_average(val_t avg, val_t sample);
    logic signed [TIME_W+1:0] err;
    err = {sample[TIME_W], sample} - {avg[TIME_W], avg};
    err = err >>> avg_shift;
    return avg + err[TIME_W:0];
  endfunction

  function automatic stats_t predict_event(logic [KIND_W-1:0] k, stamp_t ts);
    stats_t r;
    val_t   delta;
    delta = {1'b0, ts} - {1'b0, last_start};
    r.measured = '0;
    if (k == KIND_START) begin
      if (start_total != 0) begin
        r.measured = delta;
        iv_avg = fold_average(iv_avg, delta);
        if (delta > iv_peak) iv_peak = delta;
      end else begin
        // first start after a clear wipes the statistics
        iv_avg   = '0;
        run_avg  = '0;
        iv_peak  = '0;
        run_peak = '0;
      end
      if (start_total != COUNT_MAX) start_total = start_total + 1'b1;
      last_start = ts;
      run_total  = '0;
    end else if (k == KIND_STOP) begin
      run_total = run_total + delta;
      run_avg   = fold_average(run_avg, run_total);
      if (run_total > run_peak) run_peak = run_total;
      r.measured = run_total;
    end else if (k == KIND_CLEAR) begin
      start_total = '0;
    end
    r.count  = start_total;
    r.avg_iv = iv_avg;
    r.max_iv = iv_peak;
    r.avg_rn = run_avg;
    r.max_rn = run_peak;
    return r;
  endfunction

  function automatic stamp_t rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  function automatic stamp_t next_gap();
    case ($urandom_range(19))
      0: return '0;
      1: return stamp_t'($urandom);
      2: return rand_stamp();   // wraps often, giving negative intervals
      default: return stamp_t'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic compare_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic send_event(logic [KIND_W-1:0] k, stamp_t ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_stats.push_back(predict_event(k, ts));
    events_sent++;
    kind_seen[k]++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_avg_shift(logic [SHIFT_W-1:0] value);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    avg_shift = value;
    shifts_written++;
  endtask

  // mostly start/stop runs on a rising clock, mixed with clears, unused kinds and wild stamps
  task automatic run_random_traffic(int n_events);
    int     stops_left;
    int     pick;
    stamp_t now_ts;
    stops_left = 0;
    now_ts = rand_stamp();
    for (int i = 0; i < n_events; i++) begin
      if (i == n_events / 2) wait_all_results();
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_event(KIND_CLEAR, rand_stamp());
      end else if (pick < 6) begin
        send_event(KIND_UNUSED, rand_stamp());
      end else if (pick < 10) begin
        send_event(pick[0] ? KIND_STOP : KIND_START, rand_stamp());
      end else begin
        now_ts = now_ts + next_gap();
        if (stops_left == 0) begin
          send_event(KIND_START, now_ts);
          stops_left = $urandom_range(0, 3);
        end else begin
          send_event(KIND_STOP, now_ts);
          stops_left--;
        end
      end
    end
  endtask

  task automatic test_edge_events();
    send_event(KIND_STOP, 48'd1000);            // stop with no start yet
    send_event(KIND_UNUSED, '1);
    send_event(KIND_START, '0);                 // first start
    send_event(KIND_START, '1);                 // largest positive interval
    send_event(KIND_START, '0);                 // largest negative interval
    send_event(KIND_STOP, '1);
    send_event(KIND_STOP, '1);                  // run accumulator wraps
    send_event(KIND_CLEAR, 48'h5555_5555_5555);
    send_event(KIND_STOP, 48'd77);
    send_event(KIND_START, 48'hAAAA_AAAA_AAAA); // first start after clear
    send_event(KIND_START, 48'hAAAA_AAAA_AAAA); // zero interval
    send_event(KIND_START, 48'hAAAA_AAAA_AAB4);
    send_event(KIND_STOP, 48'hAAAA_AAAA_AAB7);
    send_event(KIND_STOP, 48'hAAAA_AAAA_AABB);
    send_event(KIND_CLEAR, '0);
    send_event(KIND_CLEAR, '1);
  endtask

  task automatic test_shift_extremes();
    write_avg_shift(4'd0);
    send_event(KIND_START, 48'd100);
    send_event(KIND_START, 48'd350);
    send_event(KIND_STOP, 48'd400);
    send_event(KIND_START, 48'd300);            // stamp goes backward
    write_avg_shift(4'd15);
    send_event(KIND_START, 48'd1000);
    send_event(KIND_START, 48'd70000);
    send_event(KIND_STOP, 48'd70500);
    send_event(KIND_STOP, 48'd0);               // negative run time
  endtask

  task automatic test_random_recv_stall();
    send_idle_pct = 6;
    recv_idle_pct = 47;
    write_avg_shift(SHIFT_W'($urandom_range(1, 14)));
    run_random_traffic(240);
  endtask

  task automatic test_random_send_gaps();
    send_idle_pct = 47;
    recv_idle_pct = 6;
    write_avg_shift(4'd15);
    run_random_traffic(230);
  endtask

  task automatic test_random_streaming();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_avg_shift(SHIFT_W'($urandom_range(1, 14)));
    run_random_traffic(230);
  endtask

  always @(posedge clk) begin : check_results
    stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual measured %0d",
                 $time, out_measured);
        errors++;
      end else begin
        want = pending_stats.pop_front();
        compare_field("measured", want.measured, out_measured);
        compare_field("run_count", want.count, out_run_count);
        compare_field("avg_interval", want.avg_iv, out_avg_interval);
        compare_field("max_interval", want.max_iv, out_max_interval);
        compare_field("avg_run", want.avg_rn, out_avg_run);
        compare_field("max_run", want.max_rn, out_max_run);
        results_seen++;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // any beat on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_stats.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_events();
    test_shift_extremes();
    test_random_recv_stall();
    test_random_send_gaps();
    test_random_streaming();
    wait_all_results();
    repeat (8) @(posedge clk);
    if (pending_stats.size() != 0) begin
      $display("%0t: expected %0d more results, actual 0", $time, pending_stats.size());
      errors++;
    end
    $display("covered %0d events (%0d start, %0d stop, %0d clear, %0d unused), %0d results",
             events_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             results_seen);
    $display("average shift set %0d times incl. 0 and 15, under sender and receiver stalls",
             shifts_written);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
